FILE: rtl/cpbf_pkg.sv
// shared widths, point layout and controller/datapath command and status types
`timescale 1ns / 1ps
`default_nettype none

package cpbf_pkg;

    localparam int COORD_W   = 16;
    localparam int DIST_W    = 2 * COORD_W + 2;
    localparam int ROOT_W    = DIST_W / 2;
    localparam int OUT_IDX_W = 10;
    localparam int S_DATA_W  = 3 * COORD_W;
    localparam int M_DATA_W  = ((DIST_W + ROOT_W + 2 * OUT_IDX_W + 7) / 8) * 8;
    localparam int M_USER_W  = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic mem_wr;
        logic pair_issue;
        logic sqrt_start;
        logic out_load;
        logic pair_valid;
        logic dropped;
    } cpbf_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic sqrt_done;
        logic out_busy;
    } cpbf_stat_t;

endpackage

`default_nettype wire

FILE: rtl/cpbf_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module cpbf_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [cpbf_pkg::DIST_W-1:0] radicand,
    output logic                            done,
    output logic [cpbf_pkg::ROOT_W-1:0]     root
);
    import cpbf_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [DIST_W-1:0] rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[DIST_W-1:DIST_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[DIST_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("root done without a running iteration");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("root done while still iterating");

endmodule

`default_nettype wire

FILE: rtl/cpbf_datapath.sv
// point memory, pairwise distance pipeline, best-pair registers and result register
`timescale 1ns / 1ps
`default_nettype none

module cpbf_datapath #(
    parameter int MAX_POINTS = 1024,
    parameter int IDX_W      = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cpbf_pkg::cpbf_cmd_t            cmd,
    output cpbf_pkg::cpbf_stat_t                stat,
    input  wire logic [IDX_W-1:0]               wr_addr,
    input  wire logic [IDX_W-1:0]               rd_addr_a,
    input  wire logic [IDX_W-1:0]               rd_addr_b,
    input  wire logic [cpbf_pkg::S_DATA_W-1:0]  point_data,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [cpbf_pkg::M_DATA_W-1:0]       m_axis_tdata,
    output logic [cpbf_pkg::M_USER_W-1:0]       m_axis_tuser
);
    import cpbf_pkg::*;

    localparam int AD_W = COORD_W;
    localparam int SQ_W = 2 * COORD_W;

    function automatic logic [AD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
        return m[AD_W-1:0];
    endfunction

    logic [S_DATA_W-1:0] mem [MAX_POINTS];

    point_t            pa_reg, pb_reg;
    logic              s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [IDX_W-1:0]  s1_i_reg, s1_j_reg, s2_i_reg, s2_j_reg;
    logic [IDX_W-1:0]  s3_i_reg, s3_j_reg, s4_i_reg, s4_j_reg;
    logic [AD_W-1:0]   adx_reg, ady_reg, adz_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0] sum_reg;

    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_i_reg, best_j_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    logic                        sqrt_done;
    logic [ROOT_W-1:0]           root;
    logic [IDX_W+OUT_IDX_W-1:0]  first_ext, second_ext;
    logic [M_DATA_W-1:0]         res_data;

    // memory: one write port for loading, two registered read ports for a pair
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= point_data;
        end
        if (cmd.pair_issue)
        begin
            pa_reg <= point_t'(mem[rd_addr_a]);
            pb_reg <= point_t'(mem[rd_addr_b]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.pair_issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_i_reg <= rd_addr_a;
        s1_j_reg <= rd_addr_b;
        s2_i_reg <= s1_i_reg;
        s2_j_reg <= s1_j_reg;
        s3_i_reg <= s2_i_reg;
        s3_j_reg <= s2_j_reg;
        s4_i_reg <= s3_i_reg;
        s4_j_reg <= s3_j_reg;
        adx_reg  <= abs_diff(pa_reg.x, pb_reg.x);
        ady_reg  <= abs_diff(pa_reg.y, pb_reg.y);
        adz_reg  <= abs_diff(pa_reg.z, pb_reg.z);
        sqx_reg  <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg  <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
        sqz_reg  <= SQ_W'(adz_reg) * SQ_W'(adz_reg);
        sum_reg  <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
    end

    // all ones is above any real distance, so the first pair always wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '1;
            best_i_reg    <= '0;
            best_j_reg    <= '0;
        end
        else if (cmd.out_load)
        begin
            best_dist_reg <= '1;
            best_i_reg    <= '0;
            best_j_reg    <= '0;
        end
        else if (s4_v_reg && (sum_reg < best_dist_reg))
        begin
            best_dist_reg <= sum_reg;
            best_i_reg    <= s4_i_reg;
            best_j_reg    <= s4_j_reg;
        end
    end

    cpbf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (best_dist_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    assign first_ext  = {{OUT_IDX_W{1'b0}}, best_i_reg};
    assign second_ext = {{OUT_IDX_W{1'b0}}, best_j_reg};
    assign res_data   = M_DATA_W'({second_ext[OUT_IDX_W-1:0], first_ext[OUT_IDX_W-1:0],
                                   root, best_dist_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= cmd.pair_valid ? res_data : '0;
            m_tuser_reg <= {cmd.dropped, cmd.pair_valid};
        end
    end

    assign stat.pipe_busy = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg;
    assign stat.sqrt_done = sqrt_done;
    assign stat.out_busy  = m_tvalid_reg & ~m_axis_tready;

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid_reg && !m_axis_tready))
        else $error("result register overwritten before transfer");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !s4_v_reg)
        else $error("result taken while pairs still in flight");

endmodule

`default_nettype wire

FILE: rtl/cpbf_ctrl.sv
// controller: point loading, pair enumeration, drain, root and result sequencing
`timescale 1ns / 1ps
`default_nettype none

module cpbf_ctrl #(
    parameter int MAX_POINTS = 1024,
    parameter int IDX_W      = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tlast,
    output logic                      s_axis_tready,
    output cpbf_pkg::cpbf_cmd_t       cmd,
    input  wire cpbf_pkg::cpbf_stat_t stat,
    output logic [IDX_W-1:0]          wr_addr,
    output logic [IDX_W-1:0]          rd_addr_a,
    output logic [IDX_W-1:0]          rd_addr_b
);
    import cpbf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             overflow_reg, overflow_next;

    logic             accept;
    logic             has_room;
    logic [CNT_W-1:0] j_inc;
    logic [CNT_W-1:0] i_inc;
    logic [CNT_W-1:0] i_inc2;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign has_room      = count_reg < CNT_W'(MAX_POINTS);
    assign j_inc         = j_reg + CNT_W'(1);
    assign i_inc         = i_reg + CNT_W'(1);
    assign i_inc2        = i_reg + CNT_W'(2);

    assign wr_addr   = count_reg[IDX_W-1:0];
    assign rd_addr_a = i_reg[IDX_W-1:0];
    assign rd_addr_b = j_reg[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        overflow_next = overflow_reg;
        cmd           = '0;
        cmd.mem_wr    = accept & has_room;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        i_next     = '0;
                        j_next     = CNT_W'(1);
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // i outer, j inner, both ascending
                if (j_reg < count_reg)
                begin
                    cmd.pair_issue = 1'b1;
                    if (j_inc < count_reg)
                    begin
                        j_next = j_inc;
                    end
                    else if (i_inc2 < count_reg)
                    begin
                        i_next = i_inc;
                        j_next = i_inc2;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.pair_valid = count_reg >= CNT_W'(2);
                    cmd.dropped    = overflow_reg;
                    count_next     = '0;
                    overflow_next  = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            overflow_reg <= overflow_next;
        end
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pair_issue |-> (j_reg > i_reg) && (j_reg < count_reg))
        else $error("pair outside loaded set or out of order");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !stat.pipe_busy)
        else $error("result stage reached with pairs in flight");

endmodule

`default_nettype wire

FILE: rtl/closest_pair_brute_force_unit.sv
// top level: brute-force 3-d closest pair search over a loaded point set
`timescale 1ns / 1ps
`default_nettype none

// loading: one point per cycle, s_axis_tready high while collecting points
// search: one pair per cycle through the two-port point memory and the distance pipeline,
//   then square root and result load
// result: one transfer per set, registered; the next set loads while it waits
// reset: rst_n clears control and the best-pair registers; the point memory is not cleared

module closest_pair_brute_force_unit #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_coord [15:0], y_coord [31:16], z_coord [47:32]
    input  wire logic [cpbf_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // min_dist_sq [33:0], min_distance [50:34], first_index [60:51],
    // second_index [70:61], zero pad [71]
    output logic [cpbf_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // pair_valid [0], points_dropped [1]
    output logic [cpbf_pkg::M_USER_W-1:0]      m_axis_tuser
);
    import cpbf_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    cpbf_cmd_t        cmd;
    cpbf_stat_t       stat;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;

    cpbf_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .stat          (stat),
        .wr_addr       (wr_addr),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b)
    );

    cpbf_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .wr_addr       (wr_addr),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .point_data    (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for the brute-force 3-d closest pair unit: directed sets, capacity overflow, random sets
`timescale 1ns / 1ps

module tb;

    import cpbf_pkg::*;

    localparam int CAPACITY    = 1024;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int END_PAD     = 64;

    typedef enum int {
        COORD_FULL,
        COORD_CLUSTER,
        COORD_EXTREME
    } coord_style_t;

    typedef struct {
        logic [33:0] dist_sq;
        logic [16:0] root;
        logic [9:0]  first_idx;
        logic [9:0]  second_idx;
        logic        valid;
        logic        dropped;
    } pair_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // predictor state: points of the set being loaded
    logic signed [15:0] held_x [CAPACITY];
    logic signed [15:0] held_y [CAPACITY];
    logic signed [15:0] held_z [CAPACITY];
    int unsigned        held_count = 0;
    logic               overflow_flag = 1'b0;

    pair_result_t pending_results [$];

    closest_pair_brute_force_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [16:0] floor_root(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r[16:0];
    endfunction

    function automatic pair_result_t search_closest_pair();
        pair_result_t res;
        longint       best;
        longint       dx;
        longint       dy;
        longint       dz;
        longint       d;
        bit           found;
        found = 1'b0;
        best = 0;
        res.first_idx = '0;
        res.second_idx = '0;
        for (int i = 0; i + 1 < held_count; i++)
        begin
            for (int j = i + 1; j < held_count; j++)
            begin
                dx = longint'(held_x[j]) - longint'(held_x[i]);
                dy = longint'(held_y[j]) - longint'(held_y[i]);
                dz = longint'(held_z[j]) - longint'(held_z[i]);
                d = dx * dx + dy * dy + dz * dz;
                // strict less-than keeps the earliest pair on ties
                if (!found || d < best)
                begin
                    found = 1'b1;
                    best = d;
                    res.first_idx = i[9:0];
                    res.second_idx = j[9:0];
                end
            end
        end
        res.valid = found;
        res.dist_sq = found ? best[33:0] : '0;
        res.root = found ? floor_root(best) : '0;
        res.dropped = overflow_flag;
        return res;
    endfunction

    task automatic load_point(point_t p, logic last);
        if (held_count < CAPACITY)
        begin
            held_x[held_count] = p.x;
            held_y[held_count] = p.y;
            held_z[held_count] = p.z;
            held_count++;
        end
        else
            overflow_flag = 1'b1;
        if (last)
        begin
            pending_results.insert(pending_results.size(), search_closest_pair());
            held_count = 0;
            overflow_flag = 1'b0;
        end
    endtask

    task automatic check_result();
        pair_result_t exp_res;
        if (pending_results.size() == 0)
        begin
            $error("result transfer with no expected result, tdata %h tuser %h",
                   m_axis_tdata, m_axis_tuser);
            fail_count++;
        end
        else
        begin
            exp_res = pending_results.pop_front();
            if (m_axis_tdata[33:0] !== exp_res.dist_sq)
            begin
                $error("min_dist_sq expected %0d got %0d", exp_res.dist_sq, m_axis_tdata[33:0]);
                fail_count++;
            end
            if (m_axis_tdata[50:34] !== exp_res.root)
            begin
                $error("min_distance expected %0d got %0d", exp_res.root, m_axis_tdata[50:34]);
                fail_count++;
            end
            if (m_axis_tdata[60:51] !== exp_res.first_idx)
            begin
                $error("first_index expected %0d got %0d", exp_res.first_idx,
                       m_axis_tdata[60:51]);
                fail_count++;
            end
            if (m_axis_tdata[70:61] !== exp_res.second_idx)
            begin
                $error("second_index expected %0d got %0d", exp_res.second_idx,
                       m_axis_tdata[70:61]);
                fail_count++;
            end
            if (m_axis_tuser[0] !== exp_res.valid)
            begin
                $error("pair_valid expected %0d got %0d", exp_res.valid, m_axis_tuser[0]);
                fail_count++;
            end
            if (m_axis_tuser[1] !== exp_res.dropped)
            begin
                $error("points_dropped expected %0d got %0d", exp_res.dropped, m_axis_tuser[1]);
                fail_count++;
            end
        end
    endtask

    // both sides of the block observed at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                load_point(point_t'(s_axis_tdata), s_axis_tlast);
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_point(point_t p, logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic point_t make_point(int x, int y, int z);
        point_t p;
        p.x = x[15:0];
        p.y = y[15:0];
        p.z = z[15:0];
        return p;
    endfunction

    function automatic logic [15:0] random_coord(coord_style_t style, logic [15:0] base);
        logic [15:0] v;
        case (style)
            COORD_FULL:    v = 16'($urandom);
            COORD_CLUSTER: v = base + 16'($urandom_range(6)) - 16'd3;
            default:
            begin
                case ($urandom_range(4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'hffff;
                    3:       v = 16'h0001;
                    default: v = 16'h0000;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic test_directed_cases();
        // a single point gives no pair
        send_point(make_point(5, -7, 9), 1'b1);
        // opposite corners: the largest distance
        send_point(make_point(-32768, -32768, -32768), 1'b0);
        send_point(make_point(32767, 32767, 32767), 1'b1);
        send_point(make_point(32767, -32768, 0), 1'b0);
        send_point(make_point(0, 0, 0), 1'b0);
        send_point(make_point(-32768, 32767, -1), 1'b1);
        // identical points, every pair at distance zero
        repeat (4)
            send_point(make_point(-1234, 4321, -32768), 1'b0);
        send_point(make_point(-1234, 4321, -32768), 1'b1);
        // equal spacing along x, tie goes to the first pair
        send_point(make_point(0, 0, 0), 1'b0);
        send_point(make_point(1, 0, 0), 1'b0);
        send_point(make_point(2, 0, 0), 1'b1);
        // root that is not exact
        send_point(make_point(-1, -1, -1), 1'b0);
        send_point(make_point(0, 0, 0), 1'b0);
        send_point(make_point(300, 200, 100), 1'b1);
        wait_all_results();
    endtask

    task automatic test_capacity_overflow();
        point_t p;
        // two points past capacity, the last one among the dropped
        for (int k = 0; k < CAPACITY + 2; k++)
        begin
            p = make_point($urandom, $urandom, $urandom);
            send_point(p, k == CAPACITY + 1);
        end
        // the following set starts clean
        send_point(make_point(10, 10, 10), 1'b0);
        send_point(make_point(11, 10, 10), 1'b1);
        wait_all_results();
    endtask

    task automatic test_random_sets(int unsigned n_items);
        int unsigned  sent;
        int unsigned  set_size;
        coord_style_t style;
        point_t       base;
        point_t       p;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(19))
                0:       set_size = 1;
                1:       set_size = $urandom_range(48, 20);
                default: set_size = $urandom_range(12, 2);
            endcase
            case ($urandom_range(5))
                0, 1, 2: style = COORD_FULL;
                3, 4:    style = COORD_CLUSTER;
                default: style = COORD_EXTREME;
            endcase
            base = make_point($urandom, $urandom, $urandom);
            for (int k = 0; k < set_size; k++)
            begin
                p.x = random_coord(style, base.x);
                p.y = random_coord(style, base.y);
                p.z = random_coord(style, base.z);
                send_point(p, k == set_size - 1);
            end
            sent += set_size;
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_directed_cases();
        test_capacity_overflow();

        set_idling(0, 0);
        test_random_sets(190);
        set_idling(56, 0);
        test_random_sets(190);
        // sender holds off until the block has drained
        wait_all_results();
        set_idling(0, 56);
        test_random_sets(190);
        set_idling(11, 11);
        test_random_sets(190);

        wait_all_results();
        repeat (END_PAD)
            @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
